/* design/script_comment_string_filter_core_defines.svh */
// Assertion macros shared by the checker of the comment filter core.
`ifndef SCRIPT_COMMENT_STRING_FILTER_CORE_DEFINES_SVH
`define SCRIPT_COMMENT_STRING_FILTER_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SCF_ASSERT_ON(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define SCF_ASSERT(label, prop, msg) \
    `SCF_ASSERT_ON(label, clk, rst_n, prop, msg)

`endif

/* design/scf_pkg.sv */
package scf_pkg;

    // Depth of the result queue; it must hold two results of one word plus slack.
    localparam int OUTQ_DEPTH = 4;

    // One result word on the output stream.
    typedef struct packed {
        logic [15:0] out_char;
        logic [31:0] line_no;
        logic        end_mark;
        logic        final_of_run;
    } scf_res_t;

    // Results produced by one accepted input word, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        scf_res_t   first;
        scf_res_t   second;
    } scf_push_t;

endpackage

/* design/scf_scan.sv */
module scf_scan import scf_pkg::*; #(
    parameter int MAX_EQUALS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        op,
    input  logic [15:0] ch,
    output scf_push_t   push
);

    localparam int EqW = $clog2(MAX_EQUALS + 1);
    localparam logic [EqW-1:0] EqMax = EqW'(MAX_EQUALS);

    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_LBRK   = 16'h005B;
    localparam logic [15:0] CH_RBRK   = 16'h005D;
    localparam logic [15:0] CH_EQ     = 16'h003D;
    localparam logic [15:0] CH_NL     = 16'h000A;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_BQUOTE = 16'h0060;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_DASH,
        M_OPEN2,
        M_OPENEQ,
        M_LINE,
        M_BLOCK
    } mode_t;

    mode_t            mode_reg, mode_next, mode_eff;
    logic [EqW-1:0]   open_eq_reg, open_eq_next;
    logic [EqW-1:0]   close_eq_reg, close_eq_next;
    logic             close_armed_reg, close_armed_next;
    logic [15:0]      quote_reg, quote_next;
    logic             esc_reg, esc_next;
    logic [31:0]      line_reg, line_next;

    logic             dash_out;
    logic             char_out;
    logic             is_nl;
    scf_res_t         dash_r, char_r, end_r;

    always_comb
    begin
        mode_next        = mode_reg;
        open_eq_next     = open_eq_reg;
        close_eq_next    = close_eq_reg;
        close_armed_next = close_armed_reg;
        quote_next       = quote_reg;
        esc_next         = esc_reg;
        line_next        = line_reg;
        push             = '0;
        dash_out         = 1'b0;
        char_out         = 1'b0;
        mode_eff         = mode_reg;
        is_nl            = (ch == CH_NL);

        dash_r.out_char     = CH_DASH;
        dash_r.line_no      = line_reg;
        dash_r.end_mark     = 1'b0;
        dash_r.final_of_run = 1'b0;

        end_r.out_char      = 16'h0000;
        end_r.line_no       = line_reg;
        end_r.end_mark      = 1'b1;
        end_r.final_of_run  = 1'b1;

        char_r.out_char     = ch;
        char_r.line_no      = line_reg + 32'(is_nl);
        char_r.end_mark     = 1'b0;
        char_r.final_of_run = 1'b1;

        if (accept)
        begin
            if (op)
            begin
                // End of text: flush a held dash, mark the end, then clear all state.
                if (mode_reg == M_DASH)
                begin
                    push.count  = 2'd2;
                    push.first  = dash_r;
                    push.second = end_r;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = end_r;
                end
                mode_next        = M_NORMAL;
                open_eq_next     = '0;
                close_eq_next    = '0;
                close_armed_next = 1'b0;
                quote_next       = '0;
                esc_next         = 1'b0;
                line_next        = '0;
            end
            else if (mode_reg == M_DASH && ch == CH_DASH)
            begin
                mode_next    = M_OPEN2;
                open_eq_next = '0;
            end
            else
            begin
                dash_out  = (mode_reg == M_DASH);
                mode_eff  = dash_out ? M_NORMAL : mode_reg;
                mode_next = mode_eff;
                line_next = line_reg + 32'(is_nl);

                case (mode_eff)
                    M_OPEN2:
                    begin
                        if (ch == CH_LBRK)
                        begin
                            mode_next    = M_OPENEQ;
                            open_eq_next = '0;
                        end
                        else if (is_nl)
                            mode_next = M_NORMAL;
                        else
                            mode_next = M_LINE;
                    end
                    M_OPENEQ:
                    begin
                        if (ch == CH_LBRK)
                        begin
                            mode_next        = M_BLOCK;
                            close_armed_next = 1'b0;
                            close_eq_next    = '0;
                        end
                        else if (ch == CH_EQ)
                            open_eq_next = (open_eq_reg >= EqMax) ? EqMax
                                                                  : open_eq_reg + 1'b1;
                        else
                        begin
                            open_eq_next = '0;
                            mode_next    = is_nl ? M_NORMAL : M_LINE;
                        end
                    end
                    M_LINE:
                    begin
                        if (is_nl)
                            mode_next = M_NORMAL;
                    end
                    M_BLOCK:
                    begin
                        if (ch == CH_RBRK)
                        begin
                            if (close_armed_reg && close_eq_reg == open_eq_reg)
                            begin
                                mode_next        = M_NORMAL;
                                open_eq_next     = '0;
                                close_armed_next = 1'b0;
                                close_eq_next    = '0;
                            end
                            else
                            begin
                                close_armed_next = 1'b1;
                                close_eq_next    = '0;
                            end
                        end
                        else if (ch == CH_EQ)
                        begin
                            if (close_armed_reg)
                                close_eq_next = (close_eq_reg >= EqMax) ? EqMax
                                                                        : close_eq_reg + 1'b1;
                        end
                        else
                        begin
                            close_armed_next = 1'b0;
                            close_eq_next    = '0;
                        end
                    end
                    default:
                    begin
                        mode_next = M_NORMAL;
                        if (quote_reg == 16'h0000)
                        begin
                            if (ch == CH_DASH)
                                mode_next = M_DASH;
                            else
                            begin
                                if (ch == CH_DQUOTE || ch == CH_SQUOTE || ch == CH_BQUOTE)
                                    quote_next = ch;
                                char_out = 1'b1;
                            end
                        end
                        else
                        begin
                            if (esc_reg)
                                esc_next = 1'b0;
                            else if (ch == CH_BSLASH)
                                esc_next = 1'b1;
                            else if (ch == quote_reg)
                                quote_next = '0;
                            char_out = 1'b1;
                        end
                    end
                endcase

                if (dash_out && char_out)
                begin
                    push.count  = 2'd2;
                    push.first  = dash_r;
                    push.second = char_r;
                end
                else if (dash_out)
                begin
                    push.count              = 2'd1;
                    push.first              = dash_r;
                    push.first.final_of_run = 1'b1;
                end
                else if (char_out)
                begin
                    push.count = 2'd1;
                    push.first = char_r;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_NORMAL;
            open_eq_reg     <= '0;
            close_eq_reg    <= '0;
            close_armed_reg <= 1'b0;
            quote_reg       <= '0;
            esc_reg         <= 1'b0;
            line_reg        <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            open_eq_reg     <= open_eq_next;
            close_eq_reg    <= close_eq_next;
            close_armed_reg <= close_armed_next;
            quote_reg       <= quote_next;
            esc_reg         <= esc_next;
            line_reg        <= line_next;
        end
    end

endmodule

/* design/scf_outq.sv */
module scf_outq import scf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  scf_push_t push,
    output logic      room,
    output logic      head_valid,
    output scf_res_t  head,
    input  logic      head_ready
);

    localparam int QW = $clog2(OUTQ_DEPTH);

    scf_res_t        entry_reg [OUTQ_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QW:0]     count_reg, count_next;
    logic            pop;

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    // Room for the two results that one word can cause.
    assign room       = (count_reg <= (QW + 1)'(OUTQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QW'(push.count);
        rd_ptr_next = rd_ptr_reg + QW'(pop);
        count_next  = count_reg + (QW + 1)'(push.count) - (QW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + QW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/script_comment_string_filter_core.sv */
// Comment stripper for script text. Each input word carries one 16-bit code
// unit (or, with tuser set, an end-of-text request); the core drops line comments
// opened by two dashes and block comments of the form "--[==[ ... ]==]", passes
// quoted strings through untouched (double, single and back quotes, with
// backslash escapes), and tags every passed unit with the number of newlines
// seen so far. The scanner state is updated in the cycle a word is accepted and
// its results are registered into a four-entry result queue, from which they
// leave in order. The input takes one word per cycle as long as the queue has
// room for two results; a word causes at most two results (a held-back dash
// followed by the next unit, or followed by the end marker), so the input rate
// is one word per cycle only while the queue has room, and the queue output
// port sets that limit. A dash outside strings is held until the next word
// shows whether a comment starts.
// The end-of-text word flushes that dash, yields an end marker (tuser set, zero
// character, current line count) and returns all state to its reset value.
module script_comment_string_filter_core import scf_pkg::*; #(
    parameter int MAX_EQUALS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ch
    input  logic        s_axis_tuser,   // [0] op (1 = end of text)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] out_char, [47:16] line_no
    output logic        m_axis_tuser,   // [0] end_mark
    output logic        m_axis_tlast    // final_of_run
);

    logic      accept;
    scf_push_t push;
    scf_res_t  head;

    // A word is taken whenever the queue can absorb its worst case of two results.
    assign accept = s_axis_tvalid && s_axis_tready;

    scf_scan #(
        .MAX_EQUALS (MAX_EQUALS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (s_axis_tuser),
        .ch     (s_axis_tdata),
        .push   (push)
    );

    scf_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (s_axis_tready),
        .head_valid (m_axis_tvalid),
        .head       (head),
        .head_ready (m_axis_tready)
    );

    assign m_axis_tdata = {head.line_no, head.out_char};
    assign m_axis_tuser = head.end_mark;
    assign m_axis_tlast = head.final_of_run;

endmodule

/* design/scf_checker.sv */
`include "script_comment_string_filter_core_defines.svh"

module scf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output word keeps its contents.
    `SCF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

    // The end marker closes its run and carries no character.
    `SCF_ASSERT(a_end_form, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[15:0] == 16'h0000, "malformed end marker")

    // The input only stalls while results are waiting in the queue.
    `SCF_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with an empty queue")

    // The rest of a two-result run is already queued when its first word leaves.
    `SCF_ASSERT(a_run_whole, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "run cut short after a non-final word")

endmodule

bind script_comment_string_filter_core scf_checker u_scf_checker (.*);

/* tb/sv/tb_top.sv */
module tb_top;
    import scf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Saturation limit of the equals count, shared with the instance below.
    localparam int EQ_LIMIT = 15;

    // Word kinds on the input tuser bit.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOT  = 1'b1;

    // Code units that the scanner treats specially.
    localparam logic [15:0] CH_DASH   = 16'h002D;
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_EQ     = 16'h003D;
    localparam logic [15:0] CH_NL     = 16'h000A;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_BQUOTE = 16'h0060;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;

    // Scanner modes of the prediction; the string state is kept apart in quote_ch.
    typedef enum logic [2:0] {
        ST_NORMAL,
        ST_DASH,
        ST_OPEN2,
        ST_OPENEQ,
        ST_LINE,
        ST_BLOCK
    } scan_state_t;

    // One input word: the kind bit and the code unit.
    typedef struct packed {
        logic        op;
        logic [15:0] ch;
    } text_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [15:0] in_data = '0;
    logic        in_user = 1'b0;
    logic        out_ready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Words still to be sent, and results still owed by the core, oldest first.
    text_word_t  pending_text[$];
    scf_res_t    expected_units[$];

    // Predicted scanner state. It starts out at the reset values.
    scan_state_t scan_st = ST_NORMAL;
    int          open_eq = 0;
    int          close_run = 0;
    logic        close_armed = 1'b0;
    logic [15:0] quote_ch = '0;
    logic        esc_pend = 1'b0;
    logic [31:0] line_cnt = '0;

    int          words_taken = 0;
    int          words_seen = 0;
    int          words_queued = 0;
    int          errors = 0;
    int          src_idle_pct = 24;
    int          snk_idle_pct = 68;
    logic        sink_hold = 1'b0;

    script_comment_string_filter_core #(
        .MAX_EQUALS(EQ_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (in_data),
        .s_axis_tuser (in_user),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(out_ready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eq_step(input int v);
        return (v >= EQ_LIMIT) ? EQ_LIMIT : v + 1;
    endfunction

    task automatic push_unit(input logic [15:0] ch, input logic [31:0] line, input logic endm);
        scf_res_t r;
        r.out_char     = ch;
        r.line_no      = line;
        r.end_mark     = endm;
        r.final_of_run = 1'b0;
        expected_units = {expected_units, r};
    endtask

    // Advances the predicted scanner by one accepted word and queues the results
    // it causes. The last result of the word carries the final flag.
    task automatic strip_word(input logic op, input logic [15:0] ch);
        int first_idx;
        first_idx = expected_units.size();
        if (op == OP_EOT)
        begin
            // A held dash goes out ahead of the end marker, then everything clears.
            if (scan_st == ST_DASH)
                push_unit(CH_DASH, line_cnt, 1'b0);
            push_unit(16'h0000, line_cnt, 1'b1);
            scan_st     = ST_NORMAL;
            open_eq     = 0;
            close_run   = 0;
            close_armed = 1'b0;
            quote_ch    = '0;
            esc_pend    = 1'b0;
            line_cnt    = '0;
        end
        else
        begin
            if (scan_st == ST_DASH)
            begin
                if (ch == CH_DASH)
                begin
                    scan_st = ST_OPEN2;
                    open_eq = 0;
                    return;
                end
                // Not a comment after all: the dash leaves with the old line count.
                push_unit(CH_DASH, line_cnt, 1'b0);
                scan_st = ST_NORMAL;
            end
            if (ch == CH_NL)
                line_cnt = line_cnt + 32'd1;
            case (scan_st)
                ST_OPEN2:
                begin
                    if (ch == CH_LBRACK)
                    begin
                        scan_st = ST_OPENEQ;
                        open_eq = 0;
                    end
                    else if (ch == CH_NL)
                        scan_st = ST_NORMAL;
                    else
                        scan_st = ST_LINE;
                end
                ST_OPENEQ:
                begin
                    if (ch == CH_LBRACK)
                    begin
                        scan_st     = ST_BLOCK;
                        close_armed = 1'b0;
                        close_run   = 0;
                    end
                    else if (ch == CH_EQ)
                        open_eq = eq_step(open_eq);
                    else
                    begin
                        open_eq = 0;
                        scan_st = (ch == CH_NL) ? ST_NORMAL : ST_LINE;
                    end
                end
                ST_LINE:
                begin
                    if (ch == CH_NL)
                        scan_st = ST_NORMAL;
                end
                ST_BLOCK:
                begin
                    if (ch == CH_RBRACK)
                    begin
                        if (close_armed && close_run == open_eq)
                        begin
                            scan_st     = ST_NORMAL;
                            open_eq     = 0;
                            close_armed = 1'b0;
                            close_run   = 0;
                        end
                        else
                        begin
                            close_armed = 1'b1;
                            close_run   = 0;
                        end
                    end
                    else if (ch == CH_EQ)
                    begin
                        if (close_armed)
                            close_run = eq_step(close_run);
                    end
                    else
                    begin
                        close_armed = 1'b0;
                        close_run   = 0;
                    end
                end
                default:
                begin
                    scan_st = ST_NORMAL;
                    if (quote_ch == 16'h0000 && ch == CH_DASH)
                        scan_st = ST_DASH;
                    else
                    begin
                        if (quote_ch == 16'h0000)
                        begin
                            if (ch == CH_DQUOTE || ch == CH_SQUOTE || ch == CH_BQUOTE)
                                quote_ch = ch;
                        end
                        else if (esc_pend)
                            esc_pend = 1'b0;
                        else if (ch == CH_BSLASH)
                            esc_pend = 1'b1;
                        else if (ch == quote_ch)
                            quote_ch = '0;
                        push_unit(ch, line_cnt, 1'b0);
                    end
                end
            endcase
        end
        if (expected_units.size() > first_idx)
            expected_units[$].final_of_run = 1'b1;
    endtask

    // Input handshake: the prediction runs on the word the core takes at this edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && s_axis_tready)
        begin
            strip_word(in_user, in_data);
            void'(pending_text.pop_front());
            words_taken++;
        end
    end

    // Output handshake: every result word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        scf_res_t exp_r;
        if (rst_n && m_axis_tvalid && out_ready)
        begin
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected result word: out_char %h line_no %h end %b last %b",
                         $time, m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tuser,
                         m_axis_tlast);
                errors++;
            end
            else
            begin
                exp_r = expected_units.pop_front();
                if (m_axis_tdata[15:0] !== exp_r.out_char)
                begin
                    $display("%0t: out_char expected %h actual %h",
                             $time, exp_r.out_char, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[47:16] !== exp_r.line_no)
                begin
                    $display("%0t: line_no expected %h actual %h",
                             $time, exp_r.line_no, m_axis_tdata[47:16]);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.end_mark)
                begin
                    $display("%0t: end_mark expected %b actual %b",
                             $time, exp_r.end_mark, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_r.final_of_run)
                begin
                    $display("%0t: final_of_run expected %b actual %b",
                             $time, exp_r.final_of_run, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Sender: a word on offer stays until taken; a new word goes out only after
    // the previous one was accepted or when the input was idle.
    always @(negedge clk)
    begin
        logic taken;
        taken = (words_taken != words_seen);
        words_seen = words_taken;
        if (rst_n && (!in_valid || taken))
        begin
            if (pending_text.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_text[0].ch;
                in_user  <= pending_text[0].op;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: ready drops at random, and for the whole of the long hold.
    always @(negedge clk)
    begin
        out_ready <= rst_n && !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic add_word(input logic op, input logic [15:0] ch);
        text_word_t w;
        w.op = op;
        w.ch = ch;
        pending_text = {pending_text, w};
        words_queued++;
    endtask

    // Mostly letters and the characters that matter to the scanner, now and then
    // any 16-bit code unit.
    function automatic logic [15:0] text_char();
        logic [15:0] picks[10];
        picks = '{CH_DASH, CH_LBRACK, CH_RBRACK, CH_EQ, CH_NL, CH_BSLASH,
                  CH_DQUOTE, CH_SQUOTE, CH_BQUOTE, CH_SPACE};
        case ($urandom_range(9))
            0, 1, 2, 3: return CH_LOWER_A + 16'($urandom_range(25));
            4:          return 16'($urandom);
            default:    return picks[$urandom_range(9)];
        endcase
    endfunction

    // Appends one fragment of script text. Half of the fragments are well formed
    // comments and strings with random content; the rest are broken openers,
    // loose text, end-of-text words and plain noise.
    task automatic add_fragment();
        int n;
        int m;
        int len;
        logic [15:0] q;
        case ($urandom_range(11))
            0, 1:
            begin
                // Line comment running to a newline.
                add_word(OP_TEXT, CH_DASH);
                add_word(OP_TEXT, CH_DASH);
                len = $urandom_range(6);
                repeat (len) add_word(OP_TEXT, text_char());
                add_word(OP_TEXT, CH_NL);
            end
            2, 3:
            begin
                // Block comment; some openers go past the equals limit, and their
                // closers then only need at least the limit.
                n = ($urandom_range(4) == 0) ? $urandom_range(EQ_LIMIT - 1, EQ_LIMIT + 3)
                                             : $urandom_range(3);
                m = (n >= EQ_LIMIT) ? $urandom_range(EQ_LIMIT, EQ_LIMIT + 3) : n;
                add_word(OP_TEXT, CH_DASH);
                add_word(OP_TEXT, CH_DASH);
                add_word(OP_TEXT, CH_LBRACK);
                repeat (n) add_word(OP_TEXT, CH_EQ);
                add_word(OP_TEXT, CH_LBRACK);
                len = $urandom_range(8);
                repeat (len) add_word(OP_TEXT, text_char());
                if ($urandom_range(2) == 0)
                begin
                    // A near miss: a closer with the wrong number of equals signs.
                    add_word(OP_TEXT, CH_RBRACK);
                    repeat (n + 1) add_word(OP_TEXT, CH_EQ);
                    add_word(OP_TEXT, text_char());
                end
                add_word(OP_TEXT, CH_RBRACK);
                repeat (m) add_word(OP_TEXT, CH_EQ);
                add_word(OP_TEXT, CH_RBRACK);
            end
            4, 5:
            begin
                // Quoted string with escapes, dashes and brackets inside.
                case ($urandom_range(2))
                    0:       q = CH_DQUOTE;
                    1:       q = CH_SQUOTE;
                    default: q = CH_BQUOTE;
                endcase
                add_word(OP_TEXT, q);
                len = $urandom_range(8);
                repeat (len)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        add_word(OP_TEXT, CH_BSLASH);
                        add_word(OP_TEXT, ($urandom_range(1) == 0) ? q : text_char());
                    end
                    else
                        add_word(OP_TEXT, text_char());
                end
                add_word(OP_TEXT, q);
            end
            6, 7:
            begin
                len = $urandom_range(1, 6);
                repeat (len) add_word(OP_TEXT, text_char());
            end
            8:
                add_word(OP_EOT, 16'($urandom));
            9:
            begin
                len = $urandom_range(1, 6);
                repeat (len) add_word(($urandom_range(15) == 0) ? OP_EOT : OP_TEXT,
                                      16'($urandom));
            end
            default:
            begin
                // Broken openers: a newline or a stray unit where the bracket
                // should be, or a block comment cut off by the end of text.
                add_word(OP_TEXT, CH_DASH);
                add_word(OP_TEXT, CH_DASH);
                case ($urandom_range(3))
                    0: add_word(OP_TEXT, CH_NL);
                    1:
                    begin
                        add_word(OP_TEXT, CH_LBRACK);
                        repeat ($urandom_range(3)) add_word(OP_TEXT, CH_EQ);
                        add_word(OP_TEXT, ($urandom_range(1) == 0) ? CH_NL : text_char());
                    end
                    2:
                    begin
                        add_word(OP_TEXT, CH_LBRACK);
                        add_word(OP_TEXT, CH_LBRACK);
                        add_word(OP_TEXT, text_char());
                        add_word(OP_EOT, 16'($urandom));
                    end
                    default: add_word(OP_TEXT, text_char());
                endcase
            end
        endcase
    endtask

    // Returns once every queued word was taken and every result has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_text.size() != 0 || expected_units.size() != 0);
        @(posedge clk);
    endtask

    task automatic run_random(input int goal);
        words_queued = 0;
        while (words_queued < goal)
            add_fragment();
    endtask

    // Main sequence: reset, a short directed run, then three random phases with
    // different idle patterns. Between phases the sender waits for a full drain.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Extreme code units.
        add_word(OP_TEXT, 16'h0000);
        add_word(OP_TEXT, 16'hFFFF);
        // Lone dash followed by a newline: the dash keeps the old line count.
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_NL);
        // Two dashes and a newline: the comment ends at once.
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_NL);
        // String with an escaped delimiter and a dash inside.
        add_word(OP_TEXT, CH_DQUOTE);
        add_word(OP_TEXT, CH_BSLASH);
        add_word(OP_TEXT, CH_DQUOTE);
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_DQUOTE);
        // Block comment with one equals sign and a newline inside.
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_TEXT, CH_LBRACK);
        add_word(OP_TEXT, CH_EQ);
        add_word(OP_TEXT, CH_LBRACK);
        add_word(OP_TEXT, CH_NL);
        add_word(OP_TEXT, CH_RBRACK);
        add_word(OP_TEXT, CH_EQ);
        add_word(OP_TEXT, CH_RBRACK);
        // End of text with a held dash, then with an open string.
        add_word(OP_TEXT, CH_DASH);
        add_word(OP_EOT, 16'h0000);
        add_word(OP_TEXT, CH_BQUOTE);
        add_word(OP_EOT, 16'hFFFF);
        wait_drained();

        run_random(250);
        wait_drained();

        src_idle_pct = 68;
        snk_idle_pct = 24;
        run_random(250);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(250);
        wait_drained();

        // Keep the clock running so that a stray extra result would still be caught.
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Long receiver stall in the first random phase: the result queue fills
    // and the core must hold off its input while the sender keeps offering.
    initial
    begin
        wait (words_taken >= 120);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (64) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
